[design/tile_pattern_cache_engine_assert.svh]
// ----------------------------------------------------------------------------
// Tile pattern cache engine - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TILE_PATTERN_CACHE_ENGINE_ASSERT_SVH
`define TILE_PATTERN_CACHE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TPCE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPCE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tpce_pkg.sv]
// ----------------------------------------------------------------------------
// Tile pattern cache engine - package
// Word types, command codes and the line conversion functions.
// ----------------------------------------------------------------------------
package tpce_pkg;

  localparam int TILE_W_MAX = 12;

  localparam logic [2:0] OP_WRITE      = 3'd0;
  localparam logic [2:0] OP_INVALIDATE = 3'd1;
  localparam logic [2:0] OP_UPDATE     = 3'd2;
  localparam logic [2:0] OP_READ       = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [14:0] word_address;
    logic [15:0] write_data;
    logic [10:0] tile_index;
    logic [2:0]  line_index;
    logic        flipped;
  } in_t;

  typedef struct packed {
    logic [31:0] line_data;
    logic [14:0] lines_updated;
  } res_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_INVALIDATE,
    CMD_UPDATE,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [TILE_W_MAX-1:0]   tile;
    logic [2:0]              line;
    logic                    odd;
    logic [15:0]             data;
    logic                    flipped;
    logic                    in_range;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WR_MARK,
    ST_RD_DATA,
    ST_UP_LIST,
    ST_UP_TILE,
    ST_UP_FLAGS,
    ST_UP_SCAN,
    ST_UP_CONV,
    ST_INV,
    ST_CLR,
    ST_EMIT
  } bk_state_t;

  // Bit k of the byte lands in bit 0 of nibble k.
  function automatic logic [31:0] spread_byte(input logic [7:0] b);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*k] = b[k];
    end
    return r;
  endfunction

  function automatic logic [31:0] planar_line(input logic [15:0] lo, input logic [15:0] hi);
    return (spread_byte(hi[15:8]) << 3) | (spread_byte(hi[7:0]) << 2)
         | (spread_byte(lo[15:8]) << 1) | spread_byte(lo[7:0]);
  endfunction

  function automatic logic [31:0] nibble_reverse(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 4] = v[4*(7-k) +: 4];
    end
    return r;
  endfunction

  function automatic logic [31:0] convert_line(input logic [15:0] lo, input logic [15:0] hi,
                                               input logic planar);
    return planar ? planar_line(lo, hi) : {lo, hi};
  endfunction

endpackage

[design/tile_pattern_cache_engine.sv]
// ----------------------------------------------------------------------------
// Tile pattern cache engine
// Video word memory plus a dirty-tracked cache of packed tile lines.
//
//   channel   direction  handshake          word
//   item      in         push / full        tpce_pkg::in_t
//   result    out        pop / empty        tpce_pkg::res_t
//   cfg       in         cfg_valid/ready    planar_mode bit
//
// Write and read each finish in a further back-end state (WR_MARK, RD_DATA)
// that uses the registered dirty-flag and line-cache reads; unused codes finish in the take cycle.
// Update passes each pending tile through the list, tile, flag and scan states, each dirty
// line through a further scan and a conversion state, then finishes in the list state.
// Invalidate sweeps every tile and clear every line entry, one entry a cycle.
// After reset a clearing pass over every line entry runs with full held high.
// A two-entry command queue and one result register let either side stall.
// ----------------------------------------------------------------------------
module tile_pattern_cache_engine #(
  parameter int TILE_COUNT = 2048
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tpce_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output tpce_pkg::res_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  import tpce_pkg::*;

  logic init_busy;
  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // Front: accept and decode, hold until the back end is free.
  tpce_front #(.TILE_COUNT(TILE_COUNT)) u_front (
    .clk, .rst, .push, .full, .item,
    .init_busy, .cmd_valid, .cmd, .cmd_take
  );

  // Back: run each command against the memories, drive the result register.
  tpce_back #(.TILE_COUNT(TILE_COUNT)) u_back (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .cmd_valid, .cmd, .cmd_take, .init_busy,
    .empty, .pop, .result
  );

`include "tile_pattern_cache_engine_assert.svh"

  `TPCE_ASSERT_IMPL(a_init_blocks, init_busy, full, "item accepted during clearing pass")
  `TPCE_ASSERT_IMPL(a_take_valid, cmd_take, cmd_valid, "back end took from empty queue")
  `TPCE_ASSERT_IMPL(a_reset_init, $past(rst), init_busy, "clearing pass missing after reset")
  `TPCE_ASSERT_NEXT(a_init_once, !init_busy, !init_busy, "clearing pass restarted")

endmodule

[design/tpce_ram.sv]
// ----------------------------------------------------------------------------
// Tile pattern cache engine - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tpce_front.sv]
// ----------------------------------------------------------------------------
// Tile pattern cache engine - front end
// Accept input words, decode and range check them, queue two commands.
// ----------------------------------------------------------------------------
module tpce_front #(
  parameter int TILE_COUNT = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tpce_pkg::in_t item,
  input  logic          init_busy,
  output logic          cmd_valid,
  output tpce_pkg::cmd_t cmd,
  input  logic          cmd_take
);

  import tpce_pkg::*;

  localparam int VID_WORDS = TILE_COUNT * 16;

  cmd_t       dec;
  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       accept;

  // Decode into a command.
  always_comb begin
    dec          = '0;
    dec.kind     = CMD_NOP;
    dec.data     = item.write_data;
    dec.flipped  = item.flipped;
    unique case (item.operation)
      OP_WRITE: begin
        dec.in_range = (32'(item.word_address) < VID_WORDS);
        dec.kind     = dec.in_range ? CMD_WRITE : CMD_NOP;
        dec.tile     = TILE_W_MAX'(item.word_address[14:4]);
        dec.line     = item.word_address[3:1];
        dec.odd      = item.word_address[0];
      end
      OP_INVALIDATE: dec.kind = CMD_INVALIDATE;
      OP_UPDATE:     dec.kind = CMD_UPDATE;
      OP_READ: begin
        dec.kind     = CMD_READ;
        dec.in_range = (32'(item.tile_index) < TILE_COUNT);
        dec.tile     = TILE_W_MAX'(item.tile_index);
        dec.line     = item.line_index;
      end
      OP_CLEAR:      dec.kind = CMD_CLEAR;
      default:       dec.kind = CMD_NOP;
    endcase
  end

  assign full      = (cnt == 2'd2) || init_busy;
  assign accept    = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= !wptr;
      end
      if (cmd_take) begin
        rptr <= !rptr;
      end
      cnt <= cnt + 2'(accept) - 2'(cmd_take);
    end
  end

endmodule

[design/tpce_back.sv]
// ----------------------------------------------------------------------------
// Tile pattern cache engine - back end
// Execute commands against video memory, dirty list and line caches.
// ----------------------------------------------------------------------------
module tpce_back #(
  parameter int TILE_COUNT = 2048
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           cmd_valid,
  input  tpce_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           init_busy,
  output logic           empty,
  input  logic           pop,
  output tpce_pkg::res_t result
);

  import tpce_pkg::*;

  localparam int TILE_AW    = $clog2(TILE_COUNT);
  localparam int LINE_DEPTH = TILE_COUNT * 8;
  localparam int LINE_AW    = TILE_AW + 3;
  localparam int CNT_W      = TILE_AW + 1;
  localparam logic [LINE_AW-1:0] LINE_LAST = LINE_AW'(LINE_DEPTH - 1);
  localparam logic [TILE_AW-1:0] TILE_LAST = TILE_AW'(TILE_COUNT - 1);
  localparam logic [CNT_W-1:0]   TILE_FULL = CNT_W'(TILE_COUNT);

  bk_state_t state, state_next;

  logic                planar;
  logic [LINE_AW-1:0]  sweep;
  logic [CNT_W-1:0]    pend_cnt;
  logic [CNT_W-1:0]    idx;
  logic [LINE_AW:0]    upd_cnt;
  logic [TILE_AW-1:0]  cur_tile;
  logic [2:0]          cur_line;
  logic                cur_flip;
  logic                cur_inr;
  logic [7:0]          flags;
  logic [2:0]          y_r;
  logic [2:0]          y_low;
  logic                out_valid;
  res_t                out_res;
  res_t                hold_res;

  logic                fin;
  res_t                fin_res;
  logic                slot_free;
  logic                append;

  logic                ev_we, od_we;
  logic [LINE_AW-1:0]  vid_waddr, vid_raddr;
  logic [15:0]         ev_rdata, od_rdata;
  logic                ln_we;
  logic [LINE_AW-1:0]  ln_waddr, ln_raddr;
  logic [31:0]         nm_wdata, fl_wdata, nm_rdata, fl_rdata, conv;
  logic                dt_we;
  logic [TILE_AW-1:0]  dt_waddr, dt_raddr;
  logic [7:0]          dt_wdata, dt_rdata;
  logic                pd_we;
  logic [TILE_AW-1:0]  pd_waddr, pd_wdata, pd_raddr, pd_rdata;

  assign cfg_ready = 1'b1;
  assign init_busy = (state == ST_INIT);
  assign empty     = !out_valid;
  assign result    = out_res;
  assign slot_free = !out_valid || pop;
  assign conv      = convert_line(ev_rdata, od_rdata, planar);
  assign append    = (dt_rdata == 8'd0) && (pend_cnt < TILE_FULL);

  always_comb begin
    y_low = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (flags[k]) begin
        y_low = 3'(k);
      end
    end
  end

  tpce_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_vid_even (
    .clk, .we(ev_we), .waddr(vid_waddr), .wdata(cmd.data), .raddr(vid_raddr), .rdata(ev_rdata));
  tpce_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_vid_odd (
    .clk, .we(od_we), .waddr(vid_waddr), .wdata(cmd.data), .raddr(vid_raddr), .rdata(od_rdata));
  tpce_ram #(.WIDTH(32), .DEPTH(LINE_DEPTH)) u_normal (
    .clk, .we(ln_we), .waddr(ln_waddr), .wdata(nm_wdata), .raddr(ln_raddr), .rdata(nm_rdata));
  tpce_ram #(.WIDTH(32), .DEPTH(LINE_DEPTH)) u_flipped (
    .clk, .we(ln_we), .waddr(ln_waddr), .wdata(fl_wdata), .raddr(ln_raddr), .rdata(fl_rdata));
  tpce_ram #(.WIDTH(8), .DEPTH(TILE_COUNT)) u_dirty (
    .clk, .we(dt_we), .waddr(dt_waddr), .wdata(dt_wdata), .raddr(dt_raddr), .rdata(dt_rdata));
  tpce_ram #(.WIDTH(TILE_AW), .DEPTH(TILE_COUNT)) u_pending (
    .clk, .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata), .raddr(pd_raddr), .rdata(pd_rdata));

  // Datapath controls and finishing result.
  always_comb begin
    cmd_take  = 1'b0;
    fin       = 1'b0;
    fin_res   = '0;
    ev_we     = 1'b0;
    od_we     = 1'b0;
    vid_waddr = {TILE_AW'(cmd.tile), cmd.line};
    vid_raddr = {cur_tile, y_low};
    ln_we     = 1'b0;
    ln_waddr  = sweep;
    ln_raddr  = {TILE_AW'(cmd.tile), cmd.line};
    nm_wdata  = '0;
    fl_wdata  = '0;
    dt_we     = 1'b0;
    dt_waddr  = cur_tile;
    dt_wdata  = '0;
    dt_raddr  = TILE_AW'(cmd.tile);
    pd_we     = 1'b0;
    pd_waddr  = pend_cnt[TILE_AW-1:0];
    pd_wdata  = cur_tile;
    pd_raddr  = idx[TILE_AW-1:0];
    unique case (state)
      ST_INIT, ST_CLR: begin
        ln_we    = 1'b1;
        dt_we    = 1'b1;
        dt_waddr = sweep[LINE_AW-1:3];
        fin      = (state == ST_CLR) && (sweep == LINE_LAST);
      end
      ST_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid && cmd.kind == CMD_WRITE) begin
          ev_we = !cmd.odd;
          od_we = cmd.odd;
        end
        fin = cmd_valid && (cmd.kind == CMD_NOP);
      end
      ST_WR_MARK: begin
        dt_we    = 1'b1;
        dt_wdata = dt_rdata | (8'd1 << cur_line);
        pd_we    = append;
        fin      = 1'b1;
      end
      ST_RD_DATA: begin
        fin               = 1'b1;
        fin_res.line_data = cur_inr ? (cur_flip ? fl_rdata : nm_rdata) : 32'd0;
      end
      ST_UP_LIST: begin
        fin                   = (idx == pend_cnt);
        fin_res.lines_updated = 15'(upd_cnt);
      end
      ST_UP_TILE: dt_raddr = pd_rdata;
      ST_UP_FLAGS: ;
      ST_UP_SCAN: dt_we = (flags == 8'd0);
      ST_UP_CONV: begin
        ln_we    = 1'b1;
        ln_waddr = {cur_tile, y_r};
        nm_wdata = conv;
        fl_wdata = nibble_reverse(conv);
      end
      ST_INV: begin
        dt_we    = 1'b1;
        dt_waddr = sweep[TILE_AW-1:0];
        dt_wdata = 8'hFF;
        pd_we    = 1'b1;
        pd_waddr = sweep[TILE_AW-1:0];
        pd_wdata = sweep[TILE_AW-1:0];
        fin      = (sweep[TILE_AW-1:0] == TILE_LAST);
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:     if (sweep == LINE_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_WRITE:      state_next = ST_WR_MARK;
            CMD_READ:       state_next = ST_RD_DATA;
            CMD_UPDATE:     state_next = ST_UP_LIST;
            CMD_INVALIDATE: state_next = ST_INV;
            CMD_CLEAR:      state_next = ST_CLR;
            default:        state_next = slot_free ? ST_IDLE : ST_EMIT;
          endcase
        end
      end
      ST_UP_LIST:  if (!fin) state_next = ST_UP_TILE;
      ST_UP_TILE:  state_next = ST_UP_FLAGS;
      ST_UP_FLAGS: state_next = ST_UP_SCAN;
      ST_UP_SCAN:  state_next = (flags == 8'd0) ? ST_UP_LIST : ST_UP_CONV;
      ST_UP_CONV:  state_next = ST_UP_SCAN;
      ST_EMIT:     if (slot_free) state_next = ST_IDLE;
      default: ;
    endcase
    if (fin && state != ST_IDLE) begin
      state_next = slot_free ? ST_IDLE : ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      planar    <= 1'b0;
      sweep     <= '0;
      pend_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        planar <= cfg_data;
      end
      if (state == ST_INIT || state == ST_CLR || state == ST_INV) begin
        sweep <= sweep + 1'b1;
      end else begin
        sweep <= '0;
      end
      if (state == ST_WR_MARK && append) begin
        pend_cnt <= pend_cnt + 1'b1;
      end else if ((state == ST_UP_LIST || state == ST_CLR) && fin) begin
        pend_cnt <= '0;
      end else if (state == ST_INV && fin) begin
        pend_cnt <= TILE_FULL;
      end
      if (fin && slot_free) begin
        out_valid <= 1'b1;
      end else if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (fin && slot_free) begin
      out_res <= fin_res;
    end else if (state == ST_EMIT && slot_free) begin
      out_res <= hold_res;
    end
    if (fin && !slot_free) begin
      hold_res <= fin_res;
    end
    if (cmd_take) begin
      cur_tile <= TILE_AW'(cmd.tile);
      cur_line <= cmd.line;
      cur_flip <= cmd.flipped;
      cur_inr  <= cmd.in_range;
      idx      <= '0;
      upd_cnt  <= '0;
    end
    if (state == ST_UP_TILE) begin
      cur_tile <= pd_rdata;
    end
    if (state == ST_UP_FLAGS) begin
      flags <= dt_rdata;
    end
    if (state == ST_UP_SCAN) begin
      if (flags == 8'd0) begin
        idx <= idx + 1'b1;
      end else begin
        y_r          <= y_low;
        flags[y_low] <= 1'b0;
      end
    end
    if (state == ST_UP_CONV) begin
      upd_cnt <= upd_cnt + 1'b1;
    end
  end

endmodule
